// ===== hdl/drfb_pkg.sv =====
// Shared types and constants for the dirty-row frame buffer.
// Used by dirty_row_framebuffer, drfb_mem and drfb_checker; no dependencies.
package drfb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = X_W + Y_W;
  localparam int PIX_W  = 16;
  localparam int DIM_W  = 9;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd1;
  localparam logic [STAT_W-1:0] ST_CAP = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FILL_RD,
    S_FILL_PX,
    S_RD_WAIT,
    S_WALK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              frame_we;
    logic              frame_re;
    logic [ADDR_W-1:0] frame_addr;
    logic [PIX_W-1:0]  frame_wdata;
    logic              dirty_we;
    logic [Y_W-1:0]    dirty_waddr;
    logic              dirty_wdata;
    logic              dirty_re;
    logic [Y_W-1:0]    dirty_raddr;
  } mem_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/drfb_mem.sv =====
// Pixel store and per-row dirty flag store, both synchronous, with registered read data.
// Depends on drfb_pkg for widths and the request struct.
module drfb_mem (
  input  logic                          clk,
  input  drfb_pkg::mem_req_t            req,
  output logic [drfb_pkg::PIX_W-1:0]    frame_rdata,
  output logic                          dirty_rdata
);

  logic [drfb_pkg::PIX_W-1:0] frame [drfb_pkg::MAX_WIDTH*drfb_pkg::MAX_HEIGHT];
  logic                       dirty [drfb_pkg::MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (req.frame_we) begin
      frame[req.frame_addr] <= req.frame_wdata;
    end
    if (req.frame_re) begin
      frame_rdata <= frame[req.frame_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.dirty_we) begin
      dirty[req.dirty_waddr] <= req.dirty_wdata;
    end
    if (req.dirty_re) begin
      dirty_rdata <= dirty[req.dirty_raddr];
    end
  end

endmodule

// ===== hdl/dirty_row_framebuffer.sv =====
// Top level: op sequencer around the pixel and dirty-flag stores.
// Depends on drfb_pkg and drfb_mem.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one op per transfer: write pixel,
//   fill rectangle, flush, or read pixel. Output channel (out_valid/out_stall)
//   returns exactly one result per op, in order.
//   cfg_write/cfg_index/cfg_data set frame_width (0) and frame_height (1);
//   write them only while no op is in flight.
// Sequencing, one op at a time (in_stall high while busy):
//   write pixel runs as a one-pixel fill; read pixel reads the pixel store and
//   registers the data; a rejected op goes straight to the result. fill: row by
//   row, one pixel write per cycle on the single pixel-store port plus one
//   dirty-flag read per row. flush: one dirty flag per cycle; the row that ends a
//   run (clean or over capacity) is examined too unless the run wraps.
// Reset: a clearing pass writes zero to all 65536 pixels and sets all 256
//   dirty flags, one pixel per cycle; in_stall stays high until the pass ends.
// Stall: a finished result sits in the output register; the next op is taken
//   meanwhile and its result waits until the output register frees.
module dirty_row_framebuffer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     op,
  input  logic [drfb_pkg::PIX_W-1:0]     color,
  input  logic [drfb_pkg::X_W-1:0]       left_x,
  input  logic [drfb_pkg::Y_W-1:0]       top_y,
  input  logic [drfb_pkg::X_W-1:0]       right_x,
  input  logic [drfb_pkg::Y_W-1:0]       bottom_y,
  input  logic [drfb_pkg::DIM_W-1:0]     max_rows,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [drfb_pkg::STAT_W-1:0]    status,
  output logic [drfb_pkg::Y_W-1:0]       first_row,
  output logic [drfb_pkg::Y_W-1:0]       last_row,
  output logic [drfb_pkg::DIM_W-1:0]     row_count,
  output logic [drfb_pkg::PIX_W-1:0]     pixel,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [drfb_pkg::DIM_W-1:0]     cfg_data
);

  drfb_pkg::state_t state, state_next;
  drfb_pkg::mem_req_t req;

  logic [drfb_pkg::ADDR_W-1:0] clr_addr;
  logic [drfb_pkg::DIM_W-1:0]  cfg_w, cfg_h, w, h;
  logic [drfb_pkg::DIM_W-1:0]  dirty_total;
  logic [drfb_pkg::Y_W-1:0]    cursor;

  drfb_pkg::op_t               it_op;
  logic [drfb_pkg::PIX_W-1:0]  it_color;
  logic [drfb_pkg::X_W-1:0]    it_x0, it_x1, fx;
  logic [drfb_pkg::Y_W-1:0]    it_y0, it_y1, fy;
  logic [drfb_pkg::DIM_W-1:0]  it_cap;

  logic [drfb_pkg::Y_W-1:0]    walk_row, first_r, last_r, start_row;
  logic                        claiming;
  logic [drfb_pkg::DIM_W-1:0]  seen, cnt;
  logic [drfb_pkg::STAT_W-1:0] res_status;
  logic [drfb_pkg::PIX_W-1:0]  res_pixel;

  logic [drfb_pkg::PIX_W-1:0]  frame_rdata;
  logic                        dirty_rdata;

  logic in_accept, out_load;
  logic bad_px, bad_rect, row_end, fill_done;
  logic [drfb_pkg::DIM_W-1:0]  w_inc;
  logic [drfb_pkg::Y_W-1:0]    w_next_row;
  logic w_wrap, w_take, w_done;

  assign in_stall  = (state != drfb_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == drfb_pkg::S_RESP) && (!out_valid || !out_stall);

  assign w = drfb_pkg::clamp_dim(cfg_w, drfb_pkg::DIM_W'(drfb_pkg::MAX_WIDTH));
  assign h = drfb_pkg::clamp_dim(cfg_h, drfb_pkg::DIM_W'(drfb_pkg::MAX_HEIGHT));

  assign bad_px   = ({1'b0, it_x0} >= w) || ({1'b0, it_y0} >= h);
  assign bad_rect = bad_px || ({1'b0, it_x1} >= w) || ({1'b0, it_y1} >= h) ||
                    (it_x0 > it_x1) || (it_y0 > it_y1);

  assign start_row = ({1'b0, cursor} < h) ? cursor : '0;

  assign row_end   = (fx == it_x1);
  assign fill_done = row_end && (fy == it_y1);

  // flush walker: rdata holds the flag of walk_row
  assign w_inc      = {1'b0, walk_row} + drfb_pkg::DIM_W'(1);
  assign w_wrap     = (w_inc == h);
  assign w_next_row = w_wrap ? '0 : w_inc[drfb_pkg::Y_W-1:0];
  assign w_take     = dirty_rdata && (!claiming || (cnt < it_cap));
  always_comb begin
    if (w_take) begin
      w_done = w_wrap;
    end else if (claiming) begin
      w_done = 1'b1;
    end else begin
      w_done = ((seen + drfb_pkg::DIM_W'(1)) == h);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      drfb_pkg::S_CLEAR: begin
        if (clr_addr == '1) state_next = drfb_pkg::S_IDLE;
      end
      drfb_pkg::S_IDLE: begin
        if (in_accept) state_next = drfb_pkg::S_EXEC;
      end
      drfb_pkg::S_EXEC: begin
        case (it_op)
          drfb_pkg::OP_WRITE: state_next = bad_px ? drfb_pkg::S_RESP : drfb_pkg::S_FILL_RD;
          drfb_pkg::OP_FILL:  state_next = bad_rect ? drfb_pkg::S_RESP : drfb_pkg::S_FILL_RD;
          drfb_pkg::OP_READ:  state_next = bad_px ? drfb_pkg::S_RESP : drfb_pkg::S_RD_WAIT;
          drfb_pkg::OP_FLUSH: begin
            if (it_cap == '0 || dirty_total == '0) state_next = drfb_pkg::S_RESP;
            else state_next = drfb_pkg::S_WALK;
          end
          default: state_next = drfb_pkg::S_RESP;
        endcase
      end
      drfb_pkg::S_FILL_RD: state_next = drfb_pkg::S_FILL_PX;
      drfb_pkg::S_FILL_PX: begin
        if (fill_done) state_next = drfb_pkg::S_RESP;
        else if (row_end) state_next = drfb_pkg::S_FILL_RD;
      end
      drfb_pkg::S_RD_WAIT: state_next = drfb_pkg::S_RESP;
      drfb_pkg::S_WALK: begin
        if (w_done) state_next = drfb_pkg::S_RESP;
      end
      drfb_pkg::S_RESP: begin
        if (out_load) state_next = drfb_pkg::S_IDLE;
      end
      default: state_next = drfb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    case (state)
      drfb_pkg::S_CLEAR: begin
        req.frame_we    = 1'b1;
        req.frame_addr  = clr_addr;
        req.frame_wdata = '0;
        req.dirty_we    = (clr_addr[drfb_pkg::ADDR_W-1:drfb_pkg::Y_W] == '0);
        req.dirty_waddr = clr_addr[drfb_pkg::Y_W-1:0];
        req.dirty_wdata = 1'b1;
      end
      drfb_pkg::S_EXEC: begin
        req.frame_re    = (it_op == drfb_pkg::OP_READ) && !bad_px;
        req.frame_addr  = {it_y0, it_x0};
        req.dirty_re    = (it_op == drfb_pkg::OP_FLUSH);
        req.dirty_raddr = start_row;
      end
      drfb_pkg::S_FILL_RD: begin
        req.dirty_re    = 1'b1;
        req.dirty_raddr = fy;
      end
      drfb_pkg::S_FILL_PX: begin
        req.frame_we    = 1'b1;
        req.frame_addr  = {fy, fx};
        req.frame_wdata = it_color;
        req.dirty_we    = row_end;
        req.dirty_waddr = fy;
        req.dirty_wdata = 1'b1;
      end
      drfb_pkg::S_WALK: begin
        req.dirty_we    = w_take;
        req.dirty_waddr = walk_row;
        req.dirty_wdata = 1'b0;
        req.dirty_re    = !w_done;
        req.dirty_raddr = w_next_row;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= drfb_pkg::S_CLEAR;
      clr_addr    <= '0;
      dirty_total <= drfb_pkg::DIM_W'(drfb_pkg::MAX_HEIGHT);
      cursor      <= '0;
      cfg_w       <= drfb_pkg::DIM_W'(drfb_pkg::MAX_WIDTH);
      cfg_h       <= drfb_pkg::DIM_W'(drfb_pkg::MAX_HEIGHT);
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == drfb_pkg::S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_write && cfg_index == drfb_pkg::REG_WIDTH) cfg_w <= cfg_data;
      if (cfg_write && cfg_index == drfb_pkg::REG_HEIGHT) cfg_h <= cfg_data;
      if (state == drfb_pkg::S_FILL_PX && row_end && !dirty_rdata) begin
        dirty_total <= dirty_total + 1'b1;
      end
      if (state == drfb_pkg::S_WALK) begin
        if (w_take) begin
          dirty_total <= dirty_total - 1'b1;
          if (w_wrap) cursor <= '0;
        end else if (claiming) begin
          cursor <= walk_row;
        end
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_op      <= drfb_pkg::op_t'(op);
      it_color   <= color;
      it_x0      <= left_x;
      it_y0      <= top_y;
      it_x1      <= right_x;
      it_y1      <= bottom_y;
      it_cap     <= max_rows;
      res_status <= drfb_pkg::ST_OK;
      res_pixel  <= '0;
      first_r    <= '0;
      last_r     <= '0;
      cnt        <= '0;
    end
    case (state)
      drfb_pkg::S_EXEC: begin
        fx       <= it_x0;
        fy       <= it_y0;
        walk_row <= start_row;
        claiming <= 1'b0;
        seen     <= '0;
        case (it_op)
          drfb_pkg::OP_WRITE: begin
            if (bad_px) res_status <= drfb_pkg::ST_BAD;
            it_x1 <= it_x0;
            it_y1 <= it_y0;
          end
          drfb_pkg::OP_FILL: begin
            if (bad_rect) res_status <= drfb_pkg::ST_BAD;
          end
          drfb_pkg::OP_READ: begin
            if (bad_px) res_status <= drfb_pkg::ST_BAD;
          end
          drfb_pkg::OP_FLUSH: begin
            if (it_cap == '0) res_status <= drfb_pkg::ST_CAP;
          end
          default: res_status <= drfb_pkg::ST_BAD;
        endcase
      end
      drfb_pkg::S_FILL_PX: begin
        if (row_end) begin
          fx <= it_x0;
          fy <= fy + 1'b1;
        end else begin
          fx <= fx + 1'b1;
        end
      end
      drfb_pkg::S_RD_WAIT: res_pixel <= frame_rdata;
      drfb_pkg::S_WALK: begin
        if (w_take) begin
          cnt      <= cnt + 1'b1;
          last_r   <= walk_row;
          claiming <= 1'b1;
          walk_row <= w_next_row;
          if (!claiming) first_r <= walk_row;
        end else if (!claiming) begin
          seen     <= seen + 1'b1;
          walk_row <= w_next_row;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      status    <= res_status;
      first_row <= first_r;
      last_row  <= last_r;
      row_count <= cnt;
      pixel     <= res_pixel;
    end
  end

  drfb_mem u_mem (
    .clk         (clk),
    .req         (req),
    .frame_rdata (frame_rdata),
    .dirty_rdata (dirty_rdata)
  );

endmodule

// ===== hdl/drfb_checker.sv =====
// Port-level checks for dirty_row_framebuffer, attached by bind.
// Depends on drfb_pkg for widths and status codes.
module drfb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [drfb_pkg::STAT_W-1:0]    status,
  input logic [drfb_pkg::Y_W-1:0]       first_row,
  input logic [drfb_pkg::Y_W-1:0]       last_row,
  input logic [drfb_pkg::DIM_W-1:0]     row_count,
  input logic [drfb_pkg::PIX_W-1:0]     pixel
);

  // held result does not change under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pixel) &&
    $stable(row_count) && $stable(first_row) && $stable(last_row))
    else $error("result changed while stalled");

  // clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input taken during clearing pass");

  // a claimed run never wraps: count matches the span
  a_run_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_count != '0 |->
    ({1'b0, last_row} - {1'b0, first_row} + drfb_pkg::DIM_W'(1)) == row_count)
    else $error("flush span mismatch");

  // only flushes report rows, only reads report pixels
  a_field_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel != '0 |-> row_count == '0 && status == drfb_pkg::ST_OK)
    else $error("pixel and row report mixed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != drfb_pkg::ST_OK |->
    row_count == '0 && first_row == '0 && last_row == '0 && pixel == '0)
    else $error("error result carries data");

endmodule

bind dirty_row_framebuffer drfb_checker u_drfb_checker (.*);
